FILE: rtl/scba_pkg.sv
// Shared types and constants for the size-class block allocator.
// No dependencies.
`timescale 1ns / 1ps
package scba_pkg;

  localparam int NUM_CLASSES_DEF      = 6;
  localparam int BLOCKS_PER_CLASS_DEF = 64;
  localparam int NUM_REGS             = 6;
  localparam int CFG_IW               = 3;
  localparam int SIZE_W               = 16;

  localparam logic [SIZE_W-1:0] CLASS_SIZE_RST [NUM_REGS] = '{
    16'd8, 16'd16, 16'd24, 16'd32, 16'd48, 16'd64
  };

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;

  localparam logic [2:0] HC_EXTERNAL = 3'd6;
  localparam logic [2:0] HC_NULL     = 3'd7;

  localparam logic [2:0] ST_POOLED   = 3'd0;
  localparam logic [2:0] ST_EXTERNAL = 3'd1;
  localparam logic [2:0] ST_NULL     = 3'd2;
  localparam logic [2:0] ST_FREED    = 3'd3;
  localparam logic [2:0] ST_KEPT     = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic [SIZE_W-1:0] request_size;
    logic [2:0]        handle_class;
    logic [5:0]        handle_index;
    logic [SIZE_W-1:0] external_size;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        grant_class;
    logic [5:0]        grant_index;
    logic [SIZE_W-1:0] granted_size;
    logic [SIZE_W-1:0] copy_bytes;
    logic              release_old;
    logic [31:0]       hit_count;
    logic [31:0]       miss_count;
  } alloc_rsp_t;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'b001,
    FSM_CLEAR = 3'b010,
    FSM_EXEC  = 3'b100
  } fsm_state_t;

endpackage

FILE: rtl/size_class_block_allocator_core.sv
// Size-class block allocator: per-class free lists kept in one link memory.
// Depends on scba_pkg.
//
// Usage:
//   Input beat: in_req is taken at a rising edge with start high and busy low.
//   Result beat: out_rsp is shown for exactly one cycle with out_valid high;
//   the receiver cannot stall it, so it must be taken in that cycle.
//   Config: cfg_we writes cfg_wdata to class size register cfg_index at the
//   edge; indexes beyond the last register are dropped. Write only when idle.
// Timing:
//   The accept cycle picks the class and reads the link memory at the list
//   head; the next cycle pops/pushes and registers the result. out_valid
//   rises at the edge that ends the exec cycle; busy falls at the same edge,
//   so a new beat can be accepted while the result is shown. busy stays high
//   in the exec cycle, which uses the registered link memory read, so a new
//   beat is taken only after the last one's result is registered.
// Reset:
//   rst_n (sync, low) clears counters and sets list heads to the top block,
//   then a clearing pass writes all NUM_CLASSES * BLOCKS_PER_CLASS links (384
//   by default) one per cycle with busy high; config writes are taken anyway.
`timescale 1ns / 1ps
module size_class_block_allocator_core
  import scba_pkg::*;
#(
  parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  alloc_req_t        in_req,
  output logic              out_valid,
  output alloc_rsp_t        out_rsp,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(BLOCKS_PER_CLASS);
  localparam int LW    = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int CIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [LW-1:0] LINK_END = LW'(BLOCKS_PER_CLASS);

  fsm_state_t        state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [IW-1:0]     clr_blk_r, clr_blk_nxt;
  logic [SIZE_W-1:0] class_size_r [NUM_REGS];
  logic [LW-1:0]     free_head_r [NUM_CLASSES];
  logic [LW-1:0]     free_head_nxt [NUM_CLASSES];
  logic [LW-1:0]     in_use_r [NUM_CLASSES];
  logic [LW-1:0]     in_use_nxt [NUM_CLASSES];
  logic [31:0]       hits_r, hits_nxt;
  logic [31:0]       misses_r, misses_nxt;
  logic              out_valid_r;
  alloc_rsp_t        rsp_r, rsp_nxt;
  alloc_req_t        req_r;
  logic [CIW-1:0]    fit_r;
  logic              found_r;

  logic [LW-1:0]     link_mem [DEPTH];
  logic [LW-1:0]     mem_rd_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LW-1:0]     mem_wdata;
  logic [AW-1:0]     rd_addr;

  logic              accept;
  logic [CIW-1:0]    fit_c;
  logic              found_c;
  logic [LW-1:0]     acc_head;
  logic [IW-1:0]     acc_idx;

  // exec decode
  logic              alloc_path, free_path, re_path;
  logic              hc_pool, pv, ok, grow, need_alloc, pop, push;
  logic [CIW-1:0]    hcx;
  logic [LW-1:0]     head_fit;
  logic [SIZE_W-1:0] old_size;
  logic [LW-1:0]     push_link;

  assign busy      = (state_r != FSM_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // class fit and list head read, in the accept cycle
  always_comb begin
    fit_c   = '0;
    found_c = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (in_req.request_size <= class_size_r[c]) begin
        fit_c   = CIW'(c);
        found_c = 1'b1;
      end
    end
    acc_head = free_head_r[fit_c];
    acc_idx  = (acc_head == LINK_END) ? '0 : acc_head[IW-1:0];
    rd_addr  = AW'(int'(fit_c) * BLOCKS_PER_CLASS + int'(acc_idx));
  end

  always_comb begin
    alloc_path = (req_r.action == ACT_ALLOC) ||
                 (req_r.action == ACT_REALLOC && req_r.handle_class == HC_NULL);
    free_path  = !alloc_path && ((req_r.action == ACT_FREE) ||
                 (req_r.action == ACT_REALLOC && req_r.request_size == '0));
    re_path    = !alloc_path && !free_path && (req_r.action == ACT_REALLOC);
    hcx        = req_r.handle_class[CIW-1:0];
    hc_pool    = int'(req_r.handle_class) < NUM_CLASSES;
    pv         = hc_pool && (int'(req_r.handle_index) < BLOCKS_PER_CLASS) &&
                 (in_use_r[hcx] != '0);
    ok         = (req_r.handle_class == HC_EXTERNAL) || pv;
    if (req_r.handle_class == HC_EXTERNAL) begin
      old_size = req_r.external_size;
    end else if (int'(req_r.handle_class) < NUM_REGS) begin
      old_size = class_size_r[req_r.handle_class];
    end else begin
      old_size = '0;
    end
    grow       = re_path && ok && (req_r.request_size > old_size);
    need_alloc = (alloc_path && req_r.request_size != '0) || grow;
    head_fit   = free_head_r[fit_r];
    pop        = need_alloc && found_r && (head_fit != LINK_END);
    push       = (free_path && req_r.handle_class != HC_EXTERNAL && pv) ||
                 (grow && req_r.handle_class != HC_EXTERNAL);

    free_head_nxt = free_head_r;
    in_use_nxt    = in_use_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    if (pop) begin
      free_head_nxt[fit_r] = mem_rd_r;
      in_use_nxt[fit_r]    = in_use_r[fit_r] + 1'b1;
    end
    push_link = free_head_nxt[hcx];
    if (push) begin
      free_head_nxt[hcx] = LW'(req_r.handle_index);
      in_use_nxt[hcx]    = in_use_nxt[hcx] - 1'b1;
    end

    rsp_nxt             = '0;
    rsp_nxt.status      = ST_IGNORED;
    rsp_nxt.grant_class = HC_NULL;
    if (need_alloc) begin
      if (pop) begin
        hits_nxt             = hits_r + 32'd1;
        rsp_nxt.status       = ST_POOLED;
        rsp_nxt.grant_class  = 3'(fit_r);
        rsp_nxt.grant_index  = 6'(head_fit[IW-1:0]);
        rsp_nxt.granted_size = class_size_r[fit_r];
      end else begin
        misses_nxt           = misses_r + 32'd1;
        rsp_nxt.status       = ST_EXTERNAL;
        rsp_nxt.grant_class  = HC_EXTERNAL;
        rsp_nxt.granted_size = req_r.request_size;
      end
      if (grow) begin
        rsp_nxt.copy_bytes  = old_size;
        rsp_nxt.release_old = (req_r.handle_class == HC_EXTERNAL);
      end
    end else if (alloc_path) begin
      rsp_nxt.status = ST_NULL;
    end else if (free_path) begin
      if (req_r.handle_class == HC_EXTERNAL) begin
        rsp_nxt.status      = ST_FREED;
        rsp_nxt.release_old = 1'b1;
      end else if (pv) begin
        rsp_nxt.status = ST_FREED;
      end
    end else if (re_path && ok) begin
      rsp_nxt.status       = ST_KEPT;
      rsp_nxt.grant_class  = req_r.handle_class;
      rsp_nxt.grant_index  = (req_r.handle_class == HC_EXTERNAL) ? 6'd0 :
                             req_r.handle_index;
      rsp_nxt.granted_size = old_size;
    end
    rsp_nxt.hit_count  = hits_nxt;
    rsp_nxt.miss_count = misses_nxt;
  end

  // state sequencing and clearing pass
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clr_blk_nxt  = clr_blk_r;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_r;
    mem_wdata    = (clr_blk_r == '0) ? LINK_END : LW'(clr_blk_r - 1'b1);
    case (state_r)
      FSM_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        clr_blk_nxt  = (int'(clr_blk_r) == BLOCKS_PER_CLASS - 1) ? '0 :
                       clr_blk_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (start) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        mem_we    = push;
        mem_waddr = AW'(int'(hcx) * BLOCKS_PER_CLASS + int'(req_r.handle_index));
        mem_wdata = push_link;
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req;
      fit_r   <= fit_c;
      found_r <= found_c;
    end
    if (state_r == FSM_EXEC) begin
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      clr_addr_r  <= '0;
      clr_blk_r   <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_REGS; c++) begin
        class_size_r[c] <= CLASS_SIZE_RST[c];
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_head_r[c] <= LW'(BLOCKS_PER_CLASS - 1);
        in_use_r[c]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_blk_r   <= clr_blk_nxt;
      out_valid_r <= (state_r == FSM_EXEC);
      if (state_r == FSM_EXEC) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        free_head_r <= free_head_nxt;
        in_use_r    <= in_use_nxt;
      end
      if (cfg_we && int'(cfg_index) < NUM_REGS) begin
        class_size_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted beat gave no result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == FSM_EXEC))
    else $error("result without exec cycle");

  a_mem_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == FSM_CLEAR || state_r == FSM_EXEC))
    else $error("link write outside clear or exec");

  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rsp_r.hit_count - $past(hits_r, 2)) +
                  (rsp_r.miss_count - $past(misses_r, 2)) <= 32'd1)
    else $error("counters moved by more than one");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for size_class_block_allocator_core: a free-list predictor, a
// start/busy request driver, and a response monitor checked beat by beat.
// Depends on scba_pkg and the allocator core RTL.
`timescale 1ns / 1ps
module testbench;
  import scba_pkg::*;

  localparam int NCLS      = NUM_CLASSES_DEF;
  localparam int NBLK      = BLOCKS_PER_CLASS_DEF;
  localparam int LIST_END  = NBLK;
  localparam int CYCLE_CAP = 400000;
  localparam int CROWDED   = 110;
  localparam int MAX_SHOWN = 40;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [CFG_IW-1:0] CFG_UNUSED_IDX = CFG_IW'(NUM_REGS);

  typedef struct packed {
    logic [2:0]        cls;
    logic [5:0]        idx;
    logic [SIZE_W-1:0] bytes;
  } held_handle_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  alloc_req_t        in_req = '0;
  logic              out_valid;
  alloc_rsp_t        out_rsp;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // free-list model
  logic [SIZE_W-1:0] size_limit [NUM_REGS];
  logic [6:0]        next_free [NCLS][NBLK];
  logic [6:0]        list_head [NCLS];
  logic [15:0]       blocks_out [NCLS];
  logic [31:0]       pool_hits;
  logic [31:0]       ext_misses;

  alloc_req_t        queued_requests [$];
  alloc_rsp_t        due_responses [$];
  held_handle_t      held_handles [$];
  logic [SIZE_W-1:0] planned_sizes [NUM_REGS];
  alloc_rsp_t        want_rsp;

  int  gap_left = 0;
  bit  no_gaps = 1'b0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  err_count = 0;
  int  settings_used = 1;
  int  cycle_count = 0;

  size_class_block_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_pool();
    for (int k = 0; k < NUM_REGS; k++) size_limit[k] = CLASS_SIZE_RST[k];
    for (int c = 0; c < NCLS; c++) begin
      next_free[c][0] = 7'(LIST_END);
      for (int i = 1; i < NBLK; i++) next_free[c][i] = 7'(i - 1);
      list_head[c] = 7'(NBLK - 1);
      blocks_out[c] = '0;
    end
    pool_hits = '0;
    ext_misses = '0;
  endfunction

  function automatic bit block_in_use(input logic [2:0] c);
    return c < NCLS && blocks_out[c] != 0;
  endfunction

  function automatic void take_block(input logic [SIZE_W-1:0] n, inout alloc_rsp_t r);
    int c;
    logic [6:0] b;
    c = 0;
    while (c < NCLS && n > size_limit[c]) c++;
    if (c < NCLS && list_head[c] < LIST_END) begin
      b = list_head[c];
      list_head[c] = next_free[c][b[5:0]];
      blocks_out[c] = blocks_out[c] + 1'b1;
      pool_hits = pool_hits + 1'b1;
      r.status = ST_POOLED;
      r.grant_class = c[2:0];
      r.grant_index = b[5:0];
      r.granted_size = size_limit[c];
    end else begin
      ext_misses = ext_misses + 1'b1;
      r.status = ST_EXTERNAL;
      r.grant_class = HC_EXTERNAL;
      r.grant_index = '0;
      r.granted_size = n;
    end
  endfunction

  function automatic void return_block(input logic [2:0] c, input logic [5:0] i);
    next_free[c][i] = list_head[c];
    list_head[c] = {1'b0, i};
    blocks_out[c] = blocks_out[c] - 1'b1;
  endfunction

  function automatic alloc_rsp_t serve_request(input alloc_req_t q);
    alloc_rsp_t r;
    logic [SIZE_W-1:0] old_bytes;
    logic ext_old;
    r = '0;
    r.status = ST_IGNORED;
    r.grant_class = HC_NULL;
    ext_old = (q.handle_class == HC_EXTERNAL);
    if (q.action == ACT_ALLOC || (q.action == ACT_REALLOC && q.handle_class == HC_NULL)) begin
      if (q.request_size == '0) r.status = ST_NULL;
      else take_block(q.request_size, r);
    end else if (q.action == ACT_FREE || (q.action == ACT_REALLOC && q.request_size == '0)) begin
      if (ext_old) begin
        r.status = ST_FREED;
        r.release_old = 1'b1;
      end else if (q.handle_class != HC_NULL && block_in_use(q.handle_class)) begin
        return_block(q.handle_class, q.handle_index);
        r.status = ST_FREED;
      end
    end else if (q.action == ACT_REALLOC && (ext_old || block_in_use(q.handle_class))) begin
      old_bytes = ext_old ? q.external_size : size_limit[q.handle_class];
      if (q.request_size <= old_bytes) begin
        r.status = ST_KEPT;
        r.grant_class = q.handle_class;
        r.grant_index = ext_old ? 6'd0 : q.handle_index;
        r.granted_size = old_bytes;
      end else begin
        // new block first, then the old one goes back
        take_block(q.request_size, r);
        r.copy_bytes = old_bytes;
        if (ext_old) r.release_old = 1'b1;
        else return_block(q.handle_class, q.handle_index);
      end
    end
    r.hit_count = pool_hits;
    r.miss_count = ext_misses;
    return r;
  endfunction

  function automatic void accept_request(input alloc_req_t q);
    alloc_rsp_t r;
    r = serve_request(q);
    due_responses.push_back(r);
    beats_in++;
    if (r.status == ST_POOLED || r.status == ST_EXTERNAL || r.status == ST_KEPT)
      held_handles.push_back('{cls: r.grant_class, idx: r.grant_index, bytes: r.granted_size});
  endfunction

  task automatic report_error(input string what);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s got 0x%0h want 0x%0h", beats_out, name, got, want));
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) accept_request(in_req);
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (queued_requests.size() != 0) begin
          in_req <= queued_requests.pop_front();
          start <= 1'b1;
          if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
          gap_left <= no_gaps ? 0 : int'($urandom_range(0, 11));
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      beats_out++;
      if (due_responses.size() == 0) begin
        report_error($sformatf("beat %0d arrived with no request outstanding", beats_out));
      end else begin
        want_rsp = due_responses.pop_front();
        check_field("status", 32'(out_rsp.status), 32'(want_rsp.status));
        check_field("grant_class", 32'(out_rsp.grant_class), 32'(want_rsp.grant_class));
        check_field("grant_index", 32'(out_rsp.grant_index), 32'(want_rsp.grant_index));
        check_field("granted_size", 32'(out_rsp.granted_size), 32'(want_rsp.granted_size));
        check_field("copy_bytes", 32'(out_rsp.copy_bytes), 32'(want_rsp.copy_bytes));
        check_field("release_old", 32'(out_rsp.release_old), 32'(want_rsp.release_old));
        check_field("hit_count", out_rsp.hit_count, want_rsp.hit_count);
        check_field("miss_count", out_rsp.miss_count, want_rsp.miss_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, due_responses.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] act, input logic [SIZE_W-1:0] sz,
                          input logic [2:0] hc, input logic [5:0] hi,
                          input logic [SIZE_W-1:0] xs);
    alloc_req_t q;
    q.action = act;
    q.request_size = sz;
    q.handle_class = hc;
    q.handle_index = hi;
    q.external_size = xs;
    while (queued_requests.size() >= 2) @(negedge clk);
    queued_requests.push_back(q);
  endtask

  function automatic bit take_held(output held_handle_t h);
    int k;
    h = '0;
    if (held_handles.size() == 0) return 1'b0;
    k = $urandom_range(0, held_handles.size() - 1);
    h = held_handles[k];
    held_handles.delete(k);
    return 1'b1;
  endfunction

  function automatic bit crowded();
    for (int c = 0; c < NCLS; c++) if (blocks_out[c] >= CROWDED) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [SIZE_W-1:0] size_for_class(input int c);
    int lo, hi;
    hi = size_limit[c];
    lo = 1;
    if (c > 0) lo = size_limit[c - 1] + 1;
    if (lo > hi) lo = 1;
    return SIZE_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input int hot, input int hot_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < hot_pct) return size_for_class(hot);
    if (roll < 92) return size_for_class($urandom_range(0, NCLS - 1));
    if (roll < 96) return SIZE_W'($urandom);
    if (roll < 98) return '1;
    return '0;
  endfunction

  task automatic queue_random(input int count, input int alloc_pct, input int hot_pct);
    held_handle_t h;
    int roll, hot, kind;
    logic [SIZE_W-1:0] sz, xs;
    hot = $urandom_range(0, NCLS - 1);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (crowded()) kind = 1;
      else if (roll < alloc_pct) kind = 0;
      else if (roll < 85) kind = 1;
      else if (roll < 95) kind = 2;
      else kind = 3;
      if ((kind == 1 || kind == 2) && !take_held(h)) kind = 0;
      case (kind)
        0: push_req(ACT_ALLOC, pick_size(hot, hot_pct), 3'($urandom_range(0, 7)),
                    6'($urandom), SIZE_W'($urandom));
        1: push_req(ACT_FREE, SIZE_W'($urandom), h.cls, h.idx, h.bytes);
        2: begin
          sz = ($urandom_range(0, 19) == 0) ? '0 : pick_size(hot, hot_pct);
          xs = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom) : h.bytes;
          push_req(ACT_REALLOC, sz, h.cls, h.idx, xs);
        end
        default: push_req(2'($urandom_range(0, 3)), SIZE_W'($urandom),
                          3'($urandom_range(0, 7)), 6'($urandom), SIZE_W'($urandom));
      endcase
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (queued_requests.size() != 0 || start || busy || due_responses.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_sizes();
    for (int k = 0; k < NUM_REGS; k++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IW'(k);
      cfg_wdata <= planned_sizes[k];
      size_limit[k] = planned_sizes[k];
    end
    // beyond the last register: must be dropped
    @(posedge clk);
    cfg_index <= CFG_UNUSED_IDX;
    cfg_wdata <= SIZE_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic use_sizes(input int s0, input int s1, input int s2,
                           input int s3, input int s4, input int s5);
    planned_sizes[0] = SIZE_W'(s0);
    planned_sizes[1] = SIZE_W'(s1);
    planned_sizes[2] = SIZE_W'(s2);
    planned_sizes[3] = SIZE_W'(s3);
    planned_sizes[4] = SIZE_W'(s4);
    planned_sizes[5] = SIZE_W'(s5);
    program_sizes();
  endtask

  initial begin
    int prev;
    reset_pool();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass at reset sizes
    push_req(ACT_ALLOC, 16'd0, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_ALLOC, 16'd1, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_ALLOC, 16'd8, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_ALLOC, 16'd9, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_ALLOC, 16'd64, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_ALLOC, 16'd65, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_ALLOC, 16'hFFFF, 3'd5, 6'h3F, 16'hFFFF);
    push_req(ACT_FREE, 16'd0, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_FREE, 16'd0, HC_EXTERNAL, 6'd0, 16'hFFFF);
    push_req(ACT_FREE, 16'd0, 3'd0, 6'd63, 16'd0);
    push_req(ACT_FREE, 16'd0, 3'd3, 6'd0, 16'd0);
    push_req(ACT_FREE, 16'd0, 3'd5, 6'd63, 16'd0);
    push_req(ACT_ALLOC, 16'd12, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_FREE, 16'd0, 3'd1, 6'd62, 16'd0);
    push_req(ACT_FREE, 16'd0, 3'd1, 6'd62, 16'd0);
    push_req(ACT_UNKNOWN, 16'hFFFF, 3'd0, 6'h3F, 16'hFFFF);
    push_req(ACT_REALLOC, 16'd20, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_REALLOC, 16'd0, HC_NULL, 6'd0, 16'd0);
    push_req(ACT_REALLOC, 16'd8, 3'd0, 6'd62, 16'd0);
    push_req(ACT_REALLOC, 16'd40, 3'd0, 6'd62, 16'd0);
    push_req(ACT_REALLOC, 16'd500, HC_EXTERNAL, 6'd0, 16'd1000);
    push_req(ACT_REALLOC, 16'd30, HC_EXTERNAL, 6'd0, 16'd10);
    push_req(ACT_REALLOC, 16'd0, 3'd4, 6'd63, 16'd0);
    push_req(ACT_REALLOC, 16'd100, 3'd2, 6'd5, 16'd0);
    push_req(ACT_REALLOC, 16'd40, 3'd4, 6'd0, 16'd0);

    queue_random(90, 70, 80);
    wait_idle();
    use_sizes(1, 2, 3, 4, 5, 6);
    queue_random(90, 45, 40);
    wait_idle();
    use_sizes(65535, 65535, 65535, 65535, 65535, 65535);
    queue_random(90, 70, 80);
    wait_idle();
    use_sizes(100, 1000, 4000, 16000, 40000, 65535);
    queue_random(90, 45, 40);
    wait_idle();
    prev = 0;
    for (int k = 0; k < NUM_REGS; k++) begin
      prev = prev + $urandom_range(1, 10000);
      planned_sizes[k] = SIZE_W'(prev);
    end
    program_sizes();
    queue_random(90, 60, 60);
    wait_idle();
    for (int k = 0; k < NUM_REGS; k++) planned_sizes[k] = SIZE_W'($urandom_range(1, 65535));
    program_sizes();
    queue_random(90, 45, 40);
    wait_idle();
    use_sizes(8, 16, 24, 32, 48, 64);
    queue_random(90, 70, 80);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d requests sent, %0d responses checked across %0d size-class settings",
             beats_in, beats_out, settings_used);
    $display("pool hits %0d, external grants %0d, mismatches %0d",
             pool_hits, ext_misses, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
